// ===== design/lrupr_pkg.sv =====
// ----------------------------------------------------------------------------
// lrupr_pkg
// shared constants and controller/datapath interface types for the lru
// page replacement block
// ----------------------------------------------------------------------------
`default_nettype none

package lrupr_pkg;

    localparam int FRAMES_DEF    = 8;
    localparam int PAGE_BITS_DEF = 16;

    localparam int              CFG_W       = 4;
    localparam logic [CFG_W-1:0] CFG_RESET  = 4'd3;
    localparam int              FRAME_IDX_W = 3;
    localparam int              TOTAL_W     = 32;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic read;
        logic check;
        logic commit;
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic hit_now;
        logic last;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== design/lrupr_ram.sv =====
// ----------------------------------------------------------------------------
// lrupr_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module lrupr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/lrupr_ctrl.sv =====
// ----------------------------------------------------------------------------
// lrupr_ctrl
// sequencer: accepts a reference, walks the frames one read and one check
// at a time, then commits the update and the result
// ----------------------------------------------------------------------------
`default_nettype none

module lrupr_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire lrupr_pkg::t_dp_stat i_stat,
    output lrupr_pkg::t_dp_cmd      o_cmd,
    output logic                    o_in_stall
);
    import lrupr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_READ   = 4'b0010,
        S_CHECK  = 4'b0100,
        S_COMMIT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                // a hit ends the search early
                if (i_stat.hit_now || i_stat.last) begin
                    n_state = S_COMMIT;
                end else begin
                    n_state = S_READ;
                end
            end
            S_COMMIT: begin
                // wait for the output register to be free
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ===== design/lrupr_dp.sv =====
// ----------------------------------------------------------------------------
// lrupr_dp
// frame store, recency ranks, search registers, totals and output register
// ----------------------------------------------------------------------------
`default_nettype none

module lrupr_dp #(
    parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire lrupr_pkg::t_dp_cmd              i_cmd,
    output lrupr_pkg::t_dp_stat                  o_stat,
    input  wire logic                            i_cfg_valid,
    input  wire logic [lrupr_pkg::CFG_W-1:0]     i_cfg_frames_in_use,
    input  wire logic [PAGE_BITS-1:0]            i_page_number,
    input  wire logic                            i_out_stall,
    output logic                                 o_out_valid,
    output logic                                 o_hit,
    output logic [lrupr_pkg::FRAME_IDX_W-1:0]    o_frame_index,
    output logic                                 o_evicted_valid,
    output logic [PAGE_BITS-1:0]                 o_evicted_page,
    output logic [lrupr_pkg::TOTAL_W-1:0]        o_hit_total,
    output logic [lrupr_pkg::TOTAL_W-1:0]        o_fault_total
);
    import lrupr_pkg::*;

    localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int RANK_W = IDX_W;
    localparam int CNT_W  = $clog2(FRAMES + 1);

    // configuration
    logic [CFG_W-1:0] r_cfg;
    logic [CNT_W-1:0] active_n;

    // frame state
    logic [FRAMES-1:0] r_valid;
    logic [RANK_W-1:0] r_rank [FRAMES];
    logic [RANK_W-1:0] n_rank [FRAMES];

    // search state
    logic [PAGE_BITS-1:0] r_page;
    logic [IDX_W-1:0]     r_ptr;
    logic [CNT_W-1:0]     r_n;
    logic                 r_found;
    logic [IDX_W-1:0]     r_hit_idx;
    logic [RANK_W-1:0]    r_hit_rank;
    logic                 r_empty_found;
    logic [IDX_W-1:0]     r_empty_idx;
    logic [IDX_W-1:0]     r_vic_idx;
    logic [RANK_W-1:0]    r_vic_rank;
    logic [PAGE_BITS-1:0] r_vic_page;

    logic [TOTAL_W-1:0] r_hit_cnt;
    logic [TOTAL_W-1:0] r_fault_cnt;

    logic [PAGE_BITS-1:0] rd_data;
    logic [RANK_W-1:0]    ptr_rank;
    logic                 ptr_match;

    logic                 sel_age_all;
    logic [IDX_W-1:0]     sel_f;
    logic [RANK_W-1:0]    sel_limit;
    logic                 wr_en;

    // frames in use, clamped to one through FRAMES
    always_comb begin
        if (r_cfg == '0) begin
            active_n = CNT_W'(1);
        end else if (32'(r_cfg) > 32'(FRAMES)) begin
            active_n = CNT_W'(FRAMES);
        end else begin
            active_n = CNT_W'(r_cfg);
        end
    end

    lrupr_ram #(
        .WIDTH (PAGE_BITS),
        .DEPTH (FRAMES),
        .ADDR_W(IDX_W)
    ) u_page_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(sel_f),
        .i_wr_data(r_page),
        .i_rd_en  (i_cmd.read),
        .i_rd_addr(r_ptr),
        .o_rd_data(rd_data)
    );

    assign ptr_rank  = r_rank[r_ptr];
    assign ptr_match = r_valid[r_ptr] && (rd_data == r_page);

    assign o_stat.hit_now  = ptr_match;
    assign o_stat.last     = ((CNT_W'(r_ptr) + CNT_W'(1)) == r_n);
    assign o_stat.out_free = !o_out_valid || !i_out_stall;

    // choice of frame for the commit step
    always_comb begin
        if (r_found) begin
            sel_f       = r_hit_idx;
            sel_limit   = r_hit_rank;
            sel_age_all = 1'b0;
            wr_en       = 1'b0;
        end else if (r_empty_found) begin
            sel_f       = r_empty_idx;
            sel_limit   = r_vic_rank;
            sel_age_all = 1'b1;
            wr_en       = i_cmd.commit;
        end else begin
            sel_f       = r_vic_idx;
            sel_limit   = r_vic_rank;
            sel_age_all = 1'b0;
            wr_en       = i_cmd.commit;
        end
    end

    // selected frame goes to rank zero, younger live frames in use age by one (all live ones on a fill)
    always_comb begin
        for (int j = 0; j < FRAMES; j++) begin
            n_rank[j] = r_rank[j];
            if (IDX_W'(j) == sel_f) begin
                n_rank[j] = '0;
            end else if ((32'(j) < 32'(r_n)) && r_valid[j]
                         && (sel_age_all || (r_rank[j] < sel_limit))) begin
                n_rank[j] = r_rank[j] + RANK_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid) begin
            r_cfg <= i_cfg_frames_in_use;
        end
    end

    // search registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_page        <= i_page_number;
            r_ptr         <= '0;
            r_n           <= active_n;
            r_found       <= 1'b0;
            r_empty_found <= 1'b0;
        end else if (i_cmd.check) begin
            r_ptr <= r_ptr + IDX_W'(1);
            if (ptr_match) begin
                r_found    <= 1'b1;
                r_hit_idx  <= r_ptr;
                r_hit_rank <= ptr_rank;
            end
            if (!r_valid[r_ptr] && !r_empty_found) begin
                r_empty_found <= 1'b1;
                r_empty_idx   <= r_ptr;
            end
            // oldest frame, first one wins a tie
            if ((r_ptr == '0) || (ptr_rank > r_vic_rank)) begin
                r_vic_idx  <= r_ptr;
                r_vic_rank <= ptr_rank;
                r_vic_page <= rd_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_hit_cnt   <= '0;
            r_fault_cnt <= '0;
            for (int j = 0; j < FRAMES; j++) begin
                r_rank[j] <= '0;
            end
        end else if (i_cmd.commit) begin
            r_rank <= n_rank;
            if (!r_found) begin
                r_valid[sel_f] <= 1'b1;
            end
            if (r_found && (r_hit_cnt != '1)) begin
                r_hit_cnt <= r_hit_cnt + TOTAL_W'(1);
            end
            if (!r_found && (r_fault_cnt != '1)) begin
                r_fault_cnt <= r_fault_cnt + TOTAL_W'(1);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_hit           <= r_found;
            o_frame_index   <= FRAME_IDX_W'(sel_f);
            o_evicted_valid <= !r_found && !r_empty_found;
            o_evicted_page  <= (!r_found && !r_empty_found) ? r_vic_page : '0;
            o_hit_total     <= (r_found && (r_hit_cnt != '1))
                               ? r_hit_cnt + TOTAL_W'(1) : r_hit_cnt;
            o_fault_total   <= (!r_found && (r_fault_cnt != '1))
                               ? r_fault_cnt + TOTAL_W'(1) : r_fault_cnt;
        end
    end

endmodule

`default_nettype wire

// ===== design/lru_page_replacement_top.sv =====
// ----------------------------------------------------------------------------
// lru_page_replacement_top
// fully associative lru frame set, one page reference per transaction
// ----------------------------------------------------------------------------
// usage:
//   input channel i_in_valid / o_in_stall carries i_page_number; a transaction
//   completes when valid is high and stall is low.
//   output channel o_out_valid / i_out_stall carries one result per reference:
//   hit, frame index, evicted page and saturating hit and fault totals.
//   config channel i_cfg_valid / o_cfg_ready writes frames_in_use (reset 3);
//   write it only while the block is idle.
// timing:
//   a reference walks the frames in use one at a time through the page ram,
//   a read state and a compare state per frame, stopping at the first hit.
//   the result is registered in the commit state after the last of the
//   frames searched (1 up to frames in use); the next reference is taken
//   only once the block is back in idle after that commit.
//   the output register lets a new reference enter while a result waits;
//   a stalled receiver holds the result and stalls the commit of the next.
// reset:
//   synchronous, active low; all frames empty, totals zero, no result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_replacement_top #(
    parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [lrupr_pkg::CFG_W-1:0]   i_cfg_frames_in_use,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [PAGE_BITS-1:0]          i_page_number,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_hit,
    output logic [lrupr_pkg::FRAME_IDX_W-1:0]  o_frame_index,
    output logic                               o_evicted_valid,
    output logic [PAGE_BITS-1:0]               o_evicted_page,
    output logic [lrupr_pkg::TOTAL_W-1:0]      o_hit_total,
    output logic [lrupr_pkg::TOTAL_W-1:0]      o_fault_total
);
    import lrupr_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    assign o_cfg_ready = 1'b1;

    lrupr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_stat    (dp_stat),
        .o_cmd     (dp_cmd),
        .o_in_stall(o_in_stall)
    );

    lrupr_dp #(
        .FRAMES   (FRAMES),
        .PAGE_BITS(PAGE_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (dp_cmd),
        .o_stat             (dp_stat),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_frames_in_use(i_cfg_frames_in_use),
        .i_page_number      (i_page_number),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_hit              (o_hit),
        .o_frame_index      (o_frame_index),
        .o_evicted_valid    (o_evicted_valid),
        .o_evicted_page     (o_evicted_page),
        .o_hit_total        (o_hit_total),
        .o_fault_total      (o_fault_total)
    );

endmodule

`default_nettype wire

// ===== design/lrupr_checker.sv =====
// ----------------------------------------------------------------------------
// lrupr_checker
// port level checks for the lru page replacement block
// ----------------------------------------------------------------------------
`default_nettype none

module lrupr_checker #(
    parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         o_in_stall,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_stall,
    input wire logic                         o_hit,
    input wire logic                         o_evicted_valid,
    input wire logic [PAGE_BITS-1:0]         o_evicted_page,
    input wire logic [lrupr_pkg::TOTAL_W-1:0] o_hit_total
);

    // one reference at a time: busy right after a transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while a reference is in flight");

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hit) |-> !o_evicted_valid)
        else $error("eviction reported on a hit");

    // evicted page reads zero when nothing was replaced
    a_evict_page_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_evicted_valid) |-> (o_evicted_page == '0))
        else $error("evicted page nonzero without eviction");

    // hit total never goes down between results
    a_hit_total_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall) |=> (o_hit_total >= $past(o_hit_total)))
        else $error("hit total decreased");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_hit_total)))
        else $error("stalled result changed");

endmodule

bind lru_page_replacement_top lrupr_checker #(
    .PAGE_BITS(PAGE_BITS)
) u_lrupr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_hit          (o_hit),
    .o_evicted_valid(o_evicted_valid),
    .o_evicted_page (o_evicted_page),
    .o_hit_total    (o_hit_total)
);

`default_nettype wire

// ===== tb/lru_checker.sv =====
// ----------------------------------------------------------------------------
// lru_checker
// watches the config, reference and result channels of the lru page
// replacement block, keeps its own frame set, and compares every result
// with the expected lookup outcome
// ----------------------------------------------------------------------------
module lru_checker (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_valid,
    input  wire logic                                 i_cfg_ready,
    input  wire logic [lrupr_pkg::CFG_W-1:0]          i_cfg_frames_in_use,
    input  wire logic                                 i_in_valid,
    input  wire logic                                 i_in_stall,
    input  wire logic [lrupr_pkg::PAGE_BITS_DEF-1:0]  i_page_number,
    input  wire logic                                 i_out_valid,
    input  wire logic                                 i_out_stall,
    input  wire logic                                 i_hit,
    input  wire logic [lrupr_pkg::FRAME_IDX_W-1:0]    i_frame_index,
    input  wire logic                                 i_evicted_valid,
    input  wire logic [lrupr_pkg::PAGE_BITS_DEF-1:0]  i_evicted_page,
    input  wire logic [lrupr_pkg::TOTAL_W-1:0]        i_hit_total,
    input  wire logic [lrupr_pkg::TOTAL_W-1:0]        i_fault_total,
    output int                                        o_mismatches,
    output int                                        o_outstanding,
    output int                                        o_results,
    output int                                        o_hits,
    output int                                        o_evictions
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NFR = lrupr_pkg::FRAMES_DEF;
    localparam int PW  = lrupr_pkg::PAGE_BITS_DEF;
    localparam int TW  = lrupr_pkg::TOTAL_W;

    typedef struct packed {
        logic                              hit;
        logic [lrupr_pkg::FRAME_IDX_W-1:0] frame;
        logic                              evicted;
        logic [PW-1:0]                     evicted_page;
        logic [TW-1:0]                     hit_total;
        logic [TW-1:0]                     fault_total;
    } t_lookup;

    logic [lrupr_pkg::CFG_W-1:0] frames_cfg;
    logic                        frame_live [NFR];
    logic [PW-1:0]               frame_page [NFR];
    int unsigned                 frame_age  [NFR];
    logic [TW-1:0]               hit_sum;
    logic [TW-1:0]               fault_sum;
    t_lookup                     pending_lookups [$];

    // frame f becomes most recent, live frames younger than limit get older
    function automatic void promote_frame(input int f, input int n, input int unsigned limit);
        int j;
        for (j = 0; j < n; j++) begin
            if (j != f && frame_live[j] && frame_age[j] < limit)
                frame_age[j] = frame_age[j] + 1;
        end
        frame_age[f] = 0;
    endfunction

    function automatic t_lookup resolve_reference(input logic [PW-1:0] page);
        t_lookup r;
        int      n;
        int      f;
        int      j;
        bit      found;
        bit      empty;
        r = '0;
        f = 0;
        found = 1'b0;
        empty = 1'b0;
        if (frames_cfg == 0)
            n = 1;
        else if (int'(frames_cfg) > NFR)
            n = NFR;
        else
            n = int'(frames_cfg);
        // first matching live frame wins
        for (j = 0; j < n; j++) begin
            if (!found && frame_live[j] && frame_page[j] == page) begin
                f = j;
                found = 1'b1;
            end
        end
        if (found) begin
            promote_frame(f, n, frame_age[f]);
            if (hit_sum != '1)
                hit_sum = hit_sum + TW'(1);
        end else begin
            for (j = 0; j < n; j++) begin
                if (!empty && !frame_live[j]) begin
                    f = j;
                    empty = 1'b1;
                end
            end
            if (empty) begin
                promote_frame(f, n, 32'hFFFF_FFFF);
                frame_live[f] = 1'b1;
                frame_page[f] = page;
            end else begin
                // oldest frame, lowest index on a tie
                f = 0;
                for (j = 1; j < n; j++) begin
                    if (frame_age[j] > frame_age[f])
                        f = j;
                end
                r.evicted      = 1'b1;
                r.evicted_page = frame_page[f];
                promote_frame(f, n, frame_age[f]);
                frame_page[f] = page;
            end
            if (fault_sum != '1)
                fault_sum = fault_sum + TW'(1);
        end
        r.hit         = found;
        r.frame       = f[lrupr_pkg::FRAME_IDX_W-1:0];
        r.hit_total   = hit_sum;
        r.fault_total = fault_sum;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_lookup want;
        t_lookup got;
        int      j;
        if (!i_rst_n) begin
            frames_cfg = lrupr_pkg::CFG_RESET;
            for (j = 0; j < NFR; j++) begin
                frame_live[j] = 1'b0;
                frame_page[j] = '0;
                frame_age[j]  = 0;
            end
            hit_sum   = '0;
            fault_sum = '0;
            pending_lookups.delete();
            o_mismatches = 0;
            o_results    = 0;
            o_hits       = 0;
            o_evictions  = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                frames_cfg = i_cfg_frames_in_use;

            // results leave before this edge's reference is predicted
            if (i_out_valid && !i_out_stall) begin
                got.hit          = i_hit;
                got.frame        = i_frame_index;
                got.evicted      = i_evicted_valid;
                got.evicted_page = i_evicted_page;
                got.hit_total    = i_hit_total;
                got.fault_total  = i_fault_total;
                if (pending_lookups.size() == 0) begin
                    if (o_mismatches < 10)
                        $display("%0t: unexpected result hit=%0b frame=%0d", $realtime,
                                 got.hit, got.frame);
                    o_mismatches = o_mismatches + 1;
                end else begin
                    want = pending_lookups.pop_front();
                    o_results = o_results + 1;
                    if (got.hit !== want.hit || got.frame !== want.frame ||
                        got.evicted !== want.evicted ||
                        got.evicted_page !== want.evicted_page ||
                        got.hit_total !== want.hit_total ||
                        got.fault_total !== want.fault_total) begin
                        if (o_mismatches < 10) begin
                            $display({"%0t: result %0d expected hit=%0b frame=%0d",
                                      " evict=%0b/%h tot=%0d/%0d"},
                                     $realtime, o_results, want.hit, want.frame,
                                     want.evicted, want.evicted_page,
                                     want.hit_total, want.fault_total);
                            $display({"%0t: result %0d got      hit=%0b frame=%0d",
                                      " evict=%0b/%h tot=%0d/%0d"},
                                     $realtime, o_results, got.hit, got.frame,
                                     got.evicted, got.evicted_page,
                                     got.hit_total, got.fault_total);
                        end
                        o_mismatches = o_mismatches + 1;
                    end
                end
            end

            if (i_in_valid && !i_in_stall) begin
                want = resolve_reference(i_page_number);
                if (want.hit)
                    o_hits = o_hits + 1;
                if (want.evicted)
                    o_evictions = o_evictions + 1;
                pending_lookups.push_back(want);
            end
        end
        o_outstanding = pending_lookups.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// drives page references and frame-count writes into the lru page
// replacement block under random idle and stall bursts; lru_checker
// predicts and compares every result
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PW         = lrupr_pkg::PAGE_BITS_DEF;
    localparam int CW         = lrupr_pkg::CFG_W;
    localparam int NFR        = lrupr_pkg::FRAMES_DEF;
    localparam int RAND_REFS  = 680;
    localparam int CALM_TAIL  = 120;
    localparam int CYCLE_CAP  = 400000;
    localparam int POOL_DEPTH = 12;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_valid = 1'b0;
    logic [lrupr_pkg::CFG_W-1:0]       i_cfg_frames_in_use = '0;
    logic                              i_in_valid = 1'b0;
    logic [PW-1:0]                     i_page_number = '0;
    logic                              i_out_stall = 1'b0;
    logic                              o_cfg_ready;
    logic                              o_in_stall;
    logic                              o_out_valid;
    logic                              o_hit;
    logic [lrupr_pkg::FRAME_IDX_W-1:0] o_frame_index;
    logic                              o_evicted_valid;
    logic [PW-1:0]                     o_evicted_page;
    logic [lrupr_pkg::TOTAL_W-1:0]     o_hit_total;
    logic [lrupr_pkg::TOTAL_W-1:0]     o_fault_total;

    int mismatches;
    int outstanding;
    int results;
    int hits;
    int evictions;

    int          cycles = 0;
    int          refs_sent = 0;
    int          cfg_writes = 0;
    bit          sender_idles = 1'b0;
    bit          receiver_stalls = 1'b0;
    int          stall_left = 0;
    logic [PW-1:0] page_pool [POOL_DEPTH];

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    lru_page_replacement_top DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_frames_in_use (i_cfg_frames_in_use),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_page_number       (i_page_number),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_hit               (o_hit),
        .o_frame_index       (o_frame_index),
        .o_evicted_valid     (o_evicted_valid),
        .o_evicted_page      (o_evicted_page),
        .o_hit_total         (o_hit_total),
        .o_fault_total       (o_fault_total)
    );

    lru_checker u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_ready         (o_cfg_ready),
        .i_cfg_frames_in_use (i_cfg_frames_in_use),
        .i_in_valid          (i_in_valid),
        .i_in_stall          (o_in_stall),
        .i_page_number       (i_page_number),
        .i_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .i_hit               (o_hit),
        .i_frame_index       (o_frame_index),
        .i_evicted_valid     (o_evicted_valid),
        .i_evicted_page      (o_evicted_page),
        .i_hit_total         (o_hit_total),
        .i_fault_total       (o_fault_total),
        .o_mismatches        (mismatches),
        .o_outstanding       (outstanding),
        .o_results           (results),
        .o_hits              (hits),
        .o_evictions         (evictions)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
            $display("[lru_page_replacement_top] ERROR");
            $finish;
        end
    end

    // receiver stalls come in bursts of random length when stalls are enabled
    always @(negedge i_clk) begin
        if (!receiver_stalls) begin
            i_out_stall <= 1'b0;
        end else if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if ($urandom_range(0, 7) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 13);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic send_reference(input logic [PW-1:0] page);
        int gap;
        gap = 0;
        if (sender_idles && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 14);
        if (gap != 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_page_number <= page;
        do @(posedge i_clk); while (o_in_stall);
        refs_sent++;
    endtask

    // sender holds off until every result has been taken
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    task automatic write_frame_count(input logic [lrupr_pkg::CFG_W-1:0] count);
        drain_results();
        @(negedge i_clk);
        i_cfg_valid         <= 1'b1;
        i_cfg_frames_in_use <= count;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    initial begin
        int                          j;
        int                          span;
        int                          pick;
        int                          burst;
        int                          mode;
        int                          rand_sent;
        logic [lrupr_pkg::CFG_W-1:0] count;
        logic [PW-1:0]               page;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;

        // reset frame count: fills, a hit, then evictions
        send_reference(16'h0000);
        send_reference(16'hFFFF);
        send_reference(16'h0000);
        send_reference(16'h5555);
        send_reference(16'hAAAA);
        send_reference(16'hFFFF);
        // zero frames behaves as one
        write_frame_count(4'd0);
        send_reference(16'h1234);
        send_reference(16'h1234);
        // above the built count behaves as all frames
        write_frame_count(4'd15);
        send_reference(16'h0001);
        send_reference(16'h0002);
        send_reference(16'h0003);
        send_reference(16'h0004);
        send_reference(16'h0005);
        send_reference(16'h5555);
        // one frame: 0x0005 gets a second copy in frame 0
        write_frame_count(4'd1);
        send_reference(16'h0005);
        // hidden frames come back, duplicate resolves to the lower frame
        write_frame_count(4'd8);
        send_reference(16'h0005);
        send_reference(16'h7777);
        send_reference(16'h0002);
        write_frame_count(4'd2);
        send_reference(16'hFFFF);
        send_reference(16'h8001);
        write_frame_count(4'd9);
        send_reference(16'h4000);
        send_reference(16'h0003);

        for (j = 0; j < POOL_DEPTH; j++)
            page_pool[j] = PW'($urandom);

        rand_sent = 0;
        while (rand_sent < RAND_REFS) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0:       count = 4'd0;
                1:       count = CW'($urandom_range(9, 15));
                2:       count = 4'd1;
                3:       count = 4'd8;
                default: count = CW'($urandom_range(1, 8));
            endcase
            write_frame_count(count);

            if (RAND_REFS - rand_sent <= CALM_TAIL)
                mode = 0;
            else
                mode = $urandom_range(0, 3);
            sender_idles    = mode[0];
            receiver_stalls = mode[1];

            // a couple of fresh pages per phase, the rest stay resident
            page_pool[$urandom_range(0, POOL_DEPTH - 1)] = PW'($urandom);
            page_pool[$urandom_range(0, POOL_DEPTH - 1)] = PW'($urandom);

            span = (count == 0) ? 1 : ((int'(count) > NFR) ? NFR : int'(count));
            span = (span + 3 > POOL_DEPTH) ? POOL_DEPTH - 1 : span + 2;
            burst = $urandom_range(15, 60);
            for (j = 0; j < burst && rand_sent < RAND_REFS; j++) begin
                if ($urandom_range(0, 11) == 0)
                    page = PW'($urandom);
                else
                    page = page_pool[$urandom_range(0, span)];
                send_reference(page);
                rand_sent++;
            end
        end

        drain_results();
        repeat (24) @(negedge i_clk);

        $display("%0d references over %0d frame-count writes, zero and oversize counts included",
                 refs_sent, cfg_writes);
        $display("%0d results checked: %0d hits, %0d faults, %0d evictions",
                 results, hits, results - hits, evictions);
        if (mismatches == 0 && outstanding == 0)
            $display("[lru_page_replacement_top] OK");
        else
            $display("[lru_page_replacement_top] ERROR");
        $finish;
    end

endmodule
